[hw/rtl/cbm_pkg.sv]
`timescale 1ns / 1ps
// Shared constants and types for the cluster bitmap marking block.
// No dependencies; used by the interfaces, the top level and the checker.
package cbm_pkg;

   // default geometry, handed down as top-level parameter defaults
   localparam int CLUSTER_BITS_DEF    = 20;
   localparam int WORD_BITS_DEF       = 64;
   localparam int RUN_LENGTH_BITS_DEF = 16;
   localparam int MAX_EXTENTS_DEF     = 63;

   // fixed field widths
   localparam int VCN_BITS   = 32;
   localparam int COUNT_BITS = 21;
   localparam logic [COUNT_BITS-1:0] COUNT_RESET = 21'd1048576;

   typedef logic [1:0] kind_type;

   localparam kind_type KIND_EXTENT = 2'd0;
   localparam kind_type KIND_DONE   = 2'd1;
   localparam kind_type KIND_REJECT = 2'd2;

endpackage

[hw/rtl/cbm_if.sv]
`timescale 1ns / 1ps
// Request and response channel interfaces (valid/ready) for the bitmap block.
// Depends on cbm_pkg.
interface cbm_req_if #(
   parameter int CLUSTER_BITS    = cbm_pkg::CLUSTER_BITS_DEF,
   parameter int RUN_LENGTH_BITS = cbm_pkg::RUN_LENGTH_BITS_DEF
);
   logic                          valid;
   logic                          ready;
   logic [CLUSTER_BITS-1:0]       start_cluster;
   logic [RUN_LENGTH_BITS-1:0]    run_length;
   logic [cbm_pkg::VCN_BITS-1:0]  start_vcn;
   logic                          mark_value;

   modport source (output valid, start_cluster, run_length, start_vcn, mark_value,
                   input ready);
   modport sink   (input valid, start_cluster, run_length, start_vcn, mark_value,
                   output ready);
endinterface

interface cbm_rsp_if #(
   parameter int CLUSTER_BITS    = cbm_pkg::CLUSTER_BITS_DEF,
   parameter int RUN_LENGTH_BITS = cbm_pkg::RUN_LENGTH_BITS_DEF
);
   logic                          valid;
   logic                          ready;
   cbm_pkg::kind_type             kind;
   logic [CLUSTER_BITS-1:0]       dup_cluster;
   logic [cbm_pkg::VCN_BITS-1:0]  dup_vcn;
   logic [RUN_LENGTH_BITS-1:0]    dup_length;
   logic [RUN_LENGTH_BITS-1:0]    dup_total;
   logic                          extent_overflow;
   logic                          last;

   modport source (output valid, kind, dup_cluster, dup_vcn, dup_length, dup_total,
                   extent_overflow, last, input ready);
   modport sink   (input valid, kind, dup_cluster, dup_vcn, dup_length, dup_total,
                   extent_overflow, last, output ready);
endinterface

[hw/rtl/cbm_bitmap_ram.sv]
`timescale 1ns / 1ps
// Bitmap word store: one write port, one read port with registered read data.
// No package dependency.
module cbm_bitmap_ram #(
   parameter int ADDR_BITS = 14,
   parameter int WORD_BITS = 64
) (
   input  logic                 clock,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WORD_BITS-1:0] rd_data,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WORD_BITS-1:0] wr_data
);

   localparam int DEPTH = 1 << ADDR_BITS;

   logic [WORD_BITS-1:0] mem [DEPTH];
   logic [WORD_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/cluster_bitmap_mark_dup_extents.sv]
`timescale 1ns / 1ps
// Top level: run sequencer, word read-modify-write and bit-serial duplicate scan.
// Depends on cbm_pkg, cbm_if (cbm_req_if, cbm_rsp_if) and cbm_bitmap_ram.

// After reset the block sweeps the bitmap to zero, one word per cycle, and takes no
// request until that is done; csr writes are taken at any time. WORD_BITS must be a
// power of two. One run is handled at a time: it is accepted, range-checked, then
// each bitmap word the run touches gets a registered read, then a modify and write
// back. For each word holding duplicates while marking, the scanner then walks the
// bits from the run's first bit in that word up to its last duplicate, one cluster
// per cycle unless it waits on the response register. A run that passes the check
// then goes through the flush and done states, a rejected run only through the done
// state. An extent or done item that finds the response register full and not taken
// waits there, holding the scan, until it drains.
module cluster_bitmap_mark_dup_extents #(
   parameter int CLUSTER_BITS    = cbm_pkg::CLUSTER_BITS_DEF,
   parameter int WORD_BITS       = cbm_pkg::WORD_BITS_DEF,
   parameter int RUN_LENGTH_BITS = cbm_pkg::RUN_LENGTH_BITS_DEF,
   parameter int MAX_EXTENTS     = cbm_pkg::MAX_EXTENTS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   cbm_req_if.sink                            req_ch,
   cbm_rsp_if.source                          rsp_ch,
   input  logic                               csr_we,
   input  logic [cbm_pkg::COUNT_BITS-1:0]     csr_wdata
);

   localparam int CB    = CLUSTER_BITS;
   localparam int RLB   = RUN_LENGTH_BITS;
   localparam int VB    = cbm_pkg::VCN_BITS;
   localparam int LW    = $clog2(WORD_BITS);
   localparam int AB    = CB - LW;
   localparam int CNT_W = LW + 1;
   localparam int CW2   = (RLB > CNT_W) ? RLB : CNT_W;
   localparam int NB    = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS + 1) : 1;
   localparam int PW    = ((CB > RLB) ? CB : RLB) + 1;
   localparam int MW    = (CB > RLB) ? CB : RLB;
   localparam int CMP_W = ((MW > cbm_pkg::COUNT_BITS) ? MW : cbm_pkg::COUNT_BITS) + 2;

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_CHECK  = 3'd2;
   localparam logic [2:0] ST_READ   = 3'd3;
   localparam logic [2:0] ST_MODIFY = 3'd4;
   localparam logic [2:0] ST_SCAN   = 3'd5;
   localparam logic [2:0] ST_FLUSH  = 3'd6;
   localparam logic [2:0] ST_DONE   = 3'd7;

   // control
   logic [2:0]                      state_ff, state_in;
   logic [AB-1:0]                   clr_addr_ff, clr_addr_in;
   logic [cbm_pkg::COUNT_BITS-1:0]  count_ff, count_in;
   logic                            rsp_valid_ff, rsp_valid_in;

   // run datapath
   logic [CB-1:0]    start_ff, start_in;
   logic [RLB-1:0]   len_ff, len_in;
   logic [VB-1:0]    vcn_ff, vcn_in;
   logic             mark_ff, mark_in;
   logic             reject_ff, reject_in;
   logic [CB-1:0]    c_ff, c_in;
   logic [RLB-1:0]   off_ff, off_in;
   logic [RLB-1:0]   rem_ff, rem_in;
   logic [WORD_BITS-1:0] dup_ff, dup_in;
   logic [CB-1:0]    scl_ff, scl_in;
   logic [RLB-1:0]   soff_ff, soff_in;
   logic [CB-1:0]    pcl_ff, pcl_in;
   logic [VB-1:0]    pvcn_ff, pvcn_in;
   logic [RLB-1:0]   plen_ff, plen_in;
   logic [RLB-1:0]   total_ff, total_in;
   logic             ovf_ff, ovf_in;
   logic [NB-1:0]    n_ff, n_in;

   // response payload
   cbm_pkg::kind_type rsp_kind_ff, rsp_kind_in;
   logic [CB-1:0]     rsp_cl_ff, rsp_cl_in;
   logic [VB-1:0]     rsp_vcn_ff, rsp_vcn_in;
   logic [RLB-1:0]    rsp_len_ff, rsp_len_in;
   logic [RLB-1:0]    rsp_total_ff, rsp_total_in;
   logic              rsp_ovf_ff, rsp_ovf_in;
   logic              rsp_last_ff, rsp_last_in;

   // word unit
   logic [WORD_BITS-1:0] rd_data;
   logic [WORD_BITS-1:0] new_word;
   logic [WORD_BITS-1:0] range_mask;
   logic [LW-1:0]        lo;
   logic [CNT_W-1:0]     avail, take, end_bit;
   logic                 ram_we;
   logic [AB-1:0]        ram_waddr;
   logic [WORD_BITS-1:0] ram_wdata;

   logic             accept, out_free, push_ext, push_done, step, contig, room;
   logic [CMP_W-1:0] run_end, limit, vol_size;
   logic [RLB-1:0]   rem_after;

   assign accept       = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   // range check
   assign vol_size = CMP_W'(1) << CB;
   assign limit    = (CMP_W'(count_ff) > vol_size) ? vol_size : CMP_W'(count_ff);
   assign run_end  = CMP_W'(start_ff) + CMP_W'(len_ff);

   // bits of the current word covered by the run: [lo, lo + take)
   assign lo         = c_ff[LW-1:0];
   assign avail      = CNT_W'(WORD_BITS) - CNT_W'(lo);
   assign take       = (CW2'(rem_ff) >= CW2'(avail)) ? avail : CNT_W'(rem_ff);
   assign end_bit    = CNT_W'(lo) + take;
   assign range_mask = ({WORD_BITS{1'b1}} << lo) & ~({WORD_BITS{1'b1}} << end_bit);
   assign new_word   = mark_ff ? (rd_data | range_mask) : (rd_data & ~range_mask);
   assign rem_after  = rem_ff - RLB'(take);

   // scanned duplicate continues the open extent
   assign contig = (plen_ff != '0) && ((PW'(pcl_ff) + PW'(plen_ff)) == PW'(scl_ff));
   assign room   = (n_ff < NB'(MAX_EXTENTS));

   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      count_in    = csr_we ? csr_wdata : count_ff;
      start_in    = start_ff;
      len_in      = len_ff;
      vcn_in      = vcn_ff;
      mark_in     = mark_ff;
      reject_in   = reject_ff;
      c_in        = c_ff;
      off_in      = off_ff;
      rem_in      = rem_ff;
      dup_in      = dup_ff;
      scl_in      = scl_ff;
      soff_in     = soff_ff;
      pcl_in      = pcl_ff;
      pvcn_in     = pvcn_ff;
      plen_in     = plen_ff;
      total_in    = total_ff;
      ovf_in      = ovf_ff;
      n_in        = n_ff;
      push_ext    = 1'b0;
      push_done   = 1'b0;
      step        = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == {AB{1'b1}}) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               start_in = req_ch.start_cluster;
               len_in   = req_ch.run_length;
               vcn_in   = req_ch.start_vcn;
               mark_in  = req_ch.mark_value;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            c_in      = start_ff;
            off_in    = '0;
            rem_in    = len_ff;
            plen_in   = '0;
            total_in  = '0;
            ovf_in    = 1'b0;
            n_in      = '0;
            reject_in = (len_ff == '0) || (run_end > limit);
            state_in  = reject_in ? ST_DONE : ST_READ;
         end
         ST_READ: begin
            state_in = ST_MODIFY;
         end
         ST_MODIFY: begin
            dup_in  = mark_ff ? ((rd_data & range_mask) >> lo) : '0;
            scl_in  = c_ff;
            soff_in = off_ff;
            c_in    = c_ff + CB'(take);
            off_in  = off_ff + RLB'(take);
            rem_in  = rem_after;
            if (dup_in != '0) begin
               state_in = ST_SCAN;
            end else begin
               state_in = (rem_after == '0) ? ST_FLUSH : ST_READ;
            end
         end
         ST_SCAN: begin
            if (dup_ff == '0) begin
               state_in = (rem_ff == '0) ? ST_FLUSH : ST_READ;
            end else begin
               step = 1'b1;
               if (dup_ff[0]) begin
                  if (contig) begin
                     plen_in = plen_ff + 1'b1;
                  end else begin
                     if (plen_ff != '0 && room) begin
                        if (out_free) begin
                           push_ext = 1'b1;
                           n_in     = n_ff + 1'b1;
                        end else begin
                           step = 1'b0;
                        end
                     end else if (plen_ff != '0) begin
                        ovf_in = 1'b1;
                     end
                     if (step) begin
                        pcl_in  = scl_ff;
                        pvcn_in = vcn_ff + VB'(soff_ff);
                        plen_in = RLB'(1);
                     end
                  end
                  if (step) begin
                     total_in = total_ff + 1'b1;
                  end
               end
               if (step) begin
                  dup_in  = dup_ff >> 1;
                  scl_in  = scl_ff + 1'b1;
                  soff_in = soff_ff + 1'b1;
               end
            end
         end
         ST_FLUSH: begin
            if (plen_ff == '0) begin
               state_in = ST_DONE;
            end else if (!room) begin
               ovf_in   = 1'b1;
               state_in = ST_DONE;
            end else if (out_free) begin
               push_ext = 1'b1;
               n_in     = n_ff + 1'b1;
               plen_in  = '0;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               push_done = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_ch.ready ? 1'b0 : rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_cl_in    = rsp_cl_ff;
      rsp_vcn_in   = rsp_vcn_ff;
      rsp_len_in   = rsp_len_ff;
      rsp_total_in = rsp_total_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_last_in  = rsp_last_ff;
      if (push_ext) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = cbm_pkg::KIND_EXTENT;
         rsp_cl_in    = pcl_ff;
         rsp_vcn_in   = pvcn_ff;
         rsp_len_in   = plen_ff;
         rsp_total_in = '0;
         rsp_ovf_in   = 1'b0;
         rsp_last_in  = 1'b0;
      end else if (push_done) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = reject_ff ? cbm_pkg::KIND_REJECT : cbm_pkg::KIND_DONE;
         rsp_cl_in    = '0;
         rsp_vcn_in   = '0;
         rsp_len_in   = '0;
         rsp_total_in = total_ff;
         rsp_ovf_in   = ovf_ff;
         rsp_last_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         count_ff     <= cbm_pkg::COUNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff     <= start_in;
      len_ff       <= len_in;
      vcn_ff       <= vcn_in;
      mark_ff      <= mark_in;
      reject_ff    <= reject_in;
      c_ff         <= c_in;
      off_ff       <= off_in;
      rem_ff       <= rem_in;
      dup_ff       <= dup_in;
      scl_ff       <= scl_in;
      soff_ff      <= soff_in;
      pcl_ff       <= pcl_in;
      pvcn_ff      <= pvcn_in;
      plen_ff      <= plen_in;
      total_ff     <= total_in;
      ovf_ff       <= ovf_in;
      n_ff         <= n_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_cl_ff    <= rsp_cl_in;
      rsp_vcn_ff   <= rsp_vcn_in;
      rsp_len_ff   <= rsp_len_in;
      rsp_total_ff <= rsp_total_in;
      rsp_ovf_ff   <= rsp_ovf_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // word store: clearing sweep after reset, else write-back of the modified word
   assign ram_we    = (state_ff == ST_CLEAR) || (state_ff == ST_MODIFY);
   assign ram_waddr = (state_ff == ST_CLEAR) ? clr_addr_ff : c_ff[CB-1:LW];
   assign ram_wdata = (state_ff == ST_CLEAR) ? '0 : new_word;

   cbm_bitmap_ram #(
      .ADDR_BITS (AB),
      .WORD_BITS (WORD_BITS)
   ) u_bitmap (
      .clock   (clock),
      .rd_addr (c_ff[CB-1:LW]),
      .rd_data (rd_data),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata)
   );

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.kind            = rsp_kind_ff;
   assign rsp_ch.dup_cluster     = rsp_cl_ff;
   assign rsp_ch.dup_vcn         = rsp_vcn_ff;
   assign rsp_ch.dup_length      = rsp_len_ff;
   assign rsp_ch.dup_total       = rsp_total_ff;
   assign rsp_ch.extent_overflow = rsp_ovf_ff;
   assign rsp_ch.last            = rsp_last_ff;

endmodule

[hw/rtl/cbm_checker.sv]
`timescale 1ns / 1ps
// Port-level checker for the bitmap marking block, bound to the top level.
// Depends on cbm_pkg and cluster_bitmap_mark_dup_extents.
module cbm_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input cbm_pkg::kind_type rsp_kind,
   input logic              rsp_last,
   input logic              rsp_ovf,
   input logic              rsp_total_zero
);

   // one request in flight at a time
   a_one_run: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while a run is in progress");

   // only the done or reject item closes a run
   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_kind == cbm_pkg::KIND_EXTENT && !rsp_last) ||
                     ((rsp_kind == cbm_pkg::KIND_DONE || rsp_kind == cbm_pkg::KIND_REJECT)
                      && rsp_last)))
      else $error("last flag does not match response kind");

   a_reject_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == cbm_pkg::KIND_REJECT) |-> (rsp_total_zero && !rsp_ovf))
      else $error("rejected run reports duplicates");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_kind) && $stable(rsp_last)))
      else $error("stalled response changed");

endmodule

bind cluster_bitmap_mark_dup_extents cbm_checker u_cbm_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_kind       (rsp_ch.kind),
   .rsp_last       (rsp_ch.last),
   .rsp_ovf        (rsp_ch.extent_overflow),
   .rsp_total_zero (rsp_ch.dup_total == '0)
);
